// File: hw/rtl/mme_pkg.sv
// mme_pkg: shared constants, codes and types of the matrix multiply engine
// no dependencies; imported by mme_mac and matrix_multiply_engine_top

package mme_pkg;

    // default sizing, overridable through top-level parameters
    localparam int MAX_DIM_DEF       = 8;
    localparam int ELEMENT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int VALUE_W   = 35;
    localparam int POS_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

    // command codes
    localparam logic CMD_LOAD_A = 1'b0;
    localparam logic CMD_LOAD_B = 1'b1;

    // status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;   // restart the running sum
        logic valid;   // operand pair is on the read ports this cycle
        logic last;    // final pair of the inner dimension
    } t_mac_ctl;

endpackage

// File: hw/rtl/mme_ram.sv
// mme_ram: generic single-write, single-read memory with registered read data
// no dependencies

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mme_mac.sv
// mme_mac: shared multiply-accumulate unit, one product per cycle
// depends on mme_pkg (t_mac_ctl, VALUE_W)

module mme_mac
    import mme_pkg::t_mac_ctl;
    import mme_pkg::VALUE_W;
#(
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_mac_ctl                        i_ctl,
    input  logic signed [ELEMENT_WIDTH-1:0] i_a,
    input  logic signed [ELEMENT_WIDTH-1:0] i_b,
    output logic [VALUE_W-1:0]              o_sum,
    output logic                            o_done
);

    import mme_pkg::*;

    localparam int PROD_W = 2 * ELEMENT_WIDTH;
    localparam int EXT_W  = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_valid;
    logic                     r_prod_last;
    logic [VALUE_W-1:0]       r_sum;
    logic                     r_done;
    logic signed [EXT_W-1:0]  prod_ext;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_prod_last  <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.valid;
            r_prod_last  <= i_ctl.last;
        end
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
        end
    end

    // sign-extend the product, the sum wraps at its width
    assign prod_ext = EXT_W'(r_prod);

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_done <= 1'b0;
        end else if (i_ctl.clear) begin
            r_sum  <= '0;
            r_done <= 1'b0;
        end else if (r_prod_valid) begin
            r_sum <= r_sum + prod_ext[VALUE_W-1:0];
            if (r_prod_last) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_done = r_done;

endmodule

// File: hw/rtl/matrix_multiply_engine_top.sv
// matrix_multiply_engine_top: loads A then B, then streams out A times B (or one
// mismatch beat); depends on mme_pkg, mme_ram (element stores) and mme_mac
// (shared multiply-add). load beats: one per cycle while the input is not
// stalled; the final B beat starts the product phase, during which the input
// stalls. each product element takes one memory read pair per inner step through
// the single multiply-add unit, plus read, multiply and sum stages.
// reset (synchronous): dimensions 1, counts 0, stores kept.

module matrix_multiply_engine_top
    import mme_pkg::CFG_W;
    import mme_pkg::CFG_IDX_W;
    import mme_pkg::VALUE_W;
    import mme_pkg::POS_W;
    import mme_pkg::MAX_DIM_DEF;
    import mme_pkg::ELEMENT_WIDTH_DEF;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic signed [ELEMENT_WIDTH-1:0] i_element,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [VALUE_W-1:0]       o_product_value,
    output logic [POS_W-1:0]                o_out_row,
    output logic [POS_W-1:0]                o_out_col,
    output logic                            o_status,
    output logic                            o_last,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]                i_cfg_data
);

    import mme_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_DRAIN,
        S_ERR
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_rows_a;
    logic [CFG_W-1:0]    r_cols_a;
    logic [CFG_W-1:0]    r_rows_b;
    logic [CFG_W-1:0]    r_cols_b;
    logic [CNT_W-1:0]    r_count_a;
    logic [CNT_W-1:0]    r_count_b;
    logic [DIM_W-1:0]    r_row;
    logic [DIM_W-1:0]    r_col;
    logic [DIM_W-1:0]    r_k;
    logic [ADDR_W-1:0]   r_a_base;
    logic [ADDR_W-1:0]   r_a_addr;
    logic [ADDR_W-1:0]   r_b_addr;
    logic                r_rd_valid;
    logic                r_rd_last;
    logic                r_clear;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [DIM_W-1:0]    r_out_row;
    logic [DIM_W-1:0]    r_out_col;
    logic                r_out_status;
    logic                r_out_last;

    logic [DIM_W-1:0]    ra;
    logic [DIM_W-1:0]    ca;
    logic [DIM_W-1:0]    rb;
    logic [DIM_W-1:0]    cb;
    logic [CNT_W-1:0]    size_a;
    logic [CNT_W-1:0]    size_b;
    logic                in_acc;
    logic                out_free;
    logic                we_a;
    logic                we_b;
    logic                b_final;
    logic                k_last;
    logic                col_last;
    logic                row_last;
    logic [ELEMENT_WIDTH-1:0] rd_a;
    logic [ELEMENT_WIDTH-1:0] rd_b;
    logic [VALUE_W-1:0]  mac_sum;
    logic                mac_done;
    t_mac_ctl            mac_ctl;

    // clamp a dimension register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    assign ra     = clamp_dim(r_rows_a);
    assign ca     = clamp_dim(r_cols_a);
    assign rb     = clamp_dim(r_rows_b);
    assign cb     = clamp_dim(r_cols_b);
    assign size_a = CNT_W'(ra) * CNT_W'(ca);
    assign size_b = CNT_W'(rb) * CNT_W'(cb);

    // handshakes; a register write holds off the element beat of that cycle
    assign o_in_stall  = (r_state != S_LOAD) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // element stores
    assign we_a    = in_acc && (i_command == CMD_LOAD_A) && (r_count_a < size_a);
    assign we_b    = in_acc && (i_command == CMD_LOAD_B) && (r_count_b < size_b);
    assign b_final = we_b && ((r_count_b + CNT_W'(1)) == size_b);

    mme_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_count_a[ADDR_W-1:0]),
        .i_wdata (i_element),
        .i_raddr (r_a_addr),
        .o_rdata (rd_a)
    );

    mme_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_count_b[ADDR_W-1:0]),
        .i_wdata (i_element),
        .i_raddr (r_b_addr),
        .o_rdata (rd_b)
    );

    // shared multiply-accumulate
    assign mac_ctl = '{clear: r_clear, valid: r_rd_valid, last: r_rd_last};

    mme_mac #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_sum   (mac_sum),
        .o_done  (mac_done)
    );

    // position tests for the sequencer
    assign k_last   = (r_k == ca - DIM_W'(1));
    assign col_last = (r_col == cb - DIM_W'(1));
    assign row_last = (r_row == ra - DIM_W'(1));

    // sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_rows_a    <= CFG_W'(1);
            r_cols_a    <= CFG_W'(1);
            r_rows_b    <= CFG_W'(1);
            r_cols_b    <= CFG_W'(1);
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
            r_clear    <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid) begin
                        unique case (i_cfg_index)
                            REG_ROWS_A: r_rows_a <= i_cfg_data;
                            REG_COLS_A: r_cols_a <= i_cfg_data;
                            REG_ROWS_B: r_rows_b <= i_cfg_data;
                            REG_COLS_B: r_cols_b <= i_cfg_data;
                        endcase
                        r_count_a <= '0;
                        r_count_b <= '0;
                    end else if (we_a) begin
                        r_count_a <= r_count_a + CNT_W'(1);
                    end else if (b_final) begin
                        // last B element: start a run
                        r_count_a <= '0;
                        r_count_b <= '0;
                        r_row     <= '0;
                        r_col     <= '0;
                        r_k       <= '0;
                        r_a_base  <= '0;
                        r_a_addr  <= '0;
                        r_b_addr  <= '0;
                        r_clear   <= 1'b1;
                        r_state   <= (ca != rb) ? S_ERR : S_ISSUE;
                    end else if (we_b) begin
                        r_count_b <= r_count_b + CNT_W'(1);
                    end
                end

                // one read pair per cycle along the inner dimension
                S_ISSUE: begin
                    r_rd_valid <= 1'b1;
                    r_rd_last  <= k_last;
                    r_a_addr   <= r_a_addr + ADDR_W'(1);
                    r_b_addr   <= r_b_addr + ADDR_W'(cb);
                    r_k        <= r_k + DIM_W'(1);
                    if (k_last) begin
                        r_state <= S_DRAIN;
                    end
                end

                // wait for the sum, hand it to the result register, step on
                S_DRAIN: begin
                    if (mac_done && out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= mac_sum;
                        r_out_row    <= r_row;
                        r_out_col    <= r_col;
                        r_out_status <= STATUS_OK;
                        r_out_last   <= row_last && col_last;
                        r_k          <= '0;
                        r_clear      <= 1'b1;
                        if (row_last && col_last) begin
                            r_state <= S_LOAD;
                        end else if (col_last) begin
                            r_col    <= '0;
                            r_row    <= r_row + DIM_W'(1);
                            r_a_base <= r_a_base + ADDR_W'(ca);
                            r_a_addr <= r_a_base + ADDR_W'(ca);
                            r_b_addr <= '0;
                            r_state  <= S_ISSUE;
                        end else begin
                            r_col    <= r_col + DIM_W'(1);
                            r_a_addr <= r_a_base;
                            r_b_addr <= ADDR_W'(r_col + DIM_W'(1));
                            r_state  <= S_ISSUE;
                        end
                    end
                end

                // inner dimension mismatch: one error beat
                S_ERR: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= '0;
                        r_out_row    <= '0;
                        r_out_col    <= '0;
                        r_out_status <= STATUS_MISMATCH;
                        r_out_last   <= 1'b1;
                        r_state      <= S_LOAD;
                    end
                end
            endcase
        end
    end

    // result ports
    assign o_out_valid     = r_out_valid;
    assign o_product_value = r_out_value;
    assign o_out_row       = POS_W'(r_out_row);
    assign o_out_col       = POS_W'(r_out_col);
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

endmodule
